>>> rtl/scflc_pkg.sv
// Package for the size class free list cache: constants, codes and shared types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package scflc_pkg;

  localparam int NUM_CLASSES = 31;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_BITS   = 48;

  localparam int SIZE_W  = 32;
  localparam int REG_W   = 31;
  localparam int CLS_W   = 5;
  localparam int BLEN_W  = 6;
  localparam int DEPTH_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [REG_W-1:0] MIN_BLOCK_RST = REG_W'(1);
  localparam logic [REG_W-1:0] MAX_BLOCK_RST = REG_W'(1 << 30);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CLASS,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic                 vld;
    logic                 is_free;
    logic [CLS_W-1:0]     cls;
    logic [ADDR_BITS-1:0] addr;
  } store_op_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic pop;
  } store_res_t;

endpackage

`default_nettype wire

>>> rtl/scflc_req_if.sv
// Request channel: one alloc or free beat with size and freed address.
// Depends on scflc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scflc_req_if import scflc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [SIZE_W-1:0]    req_size;
  logic [ADDR_BITS-1:0] freed_addr;

  modport source (output valid, req_type, req_size, freed_addr, input ready);
  modport sink   (input valid, req_type, req_size, freed_addr, output ready);
endinterface

`default_nettype wire

>>> rtl/scflc_rsp_if.sv
// Response channel: one result beat per request.
// Depends on scflc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scflc_rsp_if import scflc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CLS_W-1:0]     size_class;
  logic                 bypass;
  logic                 hit;
  logic                 stack_full;
  logic [ADDR_BITS-1:0] granted_addr;

  modport source (output valid, size_class, bypass, hit, stack_full, granted_addr,
                  input ready);
  modport sink   (input valid, size_class, bypass, hit, stack_full, granted_addr,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/scflc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on scflc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scflc_cfg_if import scflc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/scflc_store.sv
// Class store: per-class fill counts in flops and the stack memory of freed addresses.
// Depends on scflc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scflc_store import scflc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire store_op_t            op_i,
  output store_res_t                res_o,
  output logic [ADDR_BITS-1:0]      rd_data_o
);

  logic [CNT_W-1:0]     counts_q [NUM_CLASSES];
  logic [ADDR_BITS-1:0] mem_q [MEM_DEPTH];
  logic [ADDR_BITS-1:0] rd_data_q;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_dec;
  logic               full;
  logic               empty;
  logic               push;
  logic               pop;
  logic [DEPTH_W-1:0] slot;
  logic [MEM_AW-1:0]  mem_addr;

  always_comb begin
    cnt      = counts_q[op_i.cls];
    cnt_dec  = cnt - CNT_W'(1);
    full     = cnt >= CNT_W'(STACK_DEPTH);
    empty    = cnt == '0;
    push     = op_i.vld && (op_i.is_free == REQ_FREE) && !full;
    pop      = op_i.vld && (op_i.is_free == REQ_ALLOC) && !empty;
    slot     = push ? cnt[DEPTH_W-1:0] : cnt_dec[DEPTH_W-1:0];
    mem_addr = MEM_AW'(op_i.cls) * MEM_AW'(STACK_DEPTH) + MEM_AW'(slot);
    res_o.hit  = push || pop;
    res_o.full = op_i.vld && (op_i.is_free == REQ_FREE) && full;
    res_o.pop  = pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts_q[i] <= '0;
      end
    end else if (push) begin
      counts_q[op_i.cls] <= cnt + CNT_W'(1);
    end else if (pop) begin
      counts_q[op_i.cls] <= cnt_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[mem_addr] <= op_i.addr;
    end
    if (pop) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/size_class_free_list_cache_top.sv
// Sequence: a request beat accepted while idle is clamped, then goes through class lookup
// with stack access, then its result is captured in the output register.
// One request is handled at a time: the next is accepted only after the last result
// is loaded into the output register, which waits while a finished result is not taken.
// Reset: all class counts clear to zero, min/max block size return to 1 and 2^30;
// the stack memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module size_class_free_list_cache_top import scflc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scflc_cfg_if.sink   cfg_i,
  scflc_req_if.sink   req_i,
  scflc_rsp_if.source rsp_o
);

  function automatic logic [BLEN_W-1:0] bit_len(input logic [REG_W-1:0] v);
    logic [BLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < REG_W; i++) begin
      if (v[i]) n = BLEN_W'(i + 1);
    end
    return n;
  endfunction

  st_e state_q, state_d;

  logic [REG_W-1:0] min_q;
  logic [REG_W-1:0] max_q;

  logic                 is_free_q;
  logic [SIZE_W-1:0]    size_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 byp_a_q;
  logic [REG_W-1:0]     sm1_q;

  logic [CLS_W-1:0] cls_q;
  logic             bypass_q;
  logic             hit_q;
  logic             full_q;
  logic             pop_q;

  logic                 out_valid_q;
  logic [CLS_W-1:0]     out_cls_q;
  logic                 out_bypass_q;
  logic                 out_hit_q;
  logic                 out_full_q;
  logic [ADDR_BITS-1:0] out_addr_q;

  logic              req_beat;
  logic              out_free;
  logic              load_out;
  logic              in_ready;
  logic              store_req;
  logic [REG_W-1:0]  s_clamp;
  logic              byp_a;
  logic [BLEN_W-1:0] blen;
  logic              bypass_c;
  store_op_t         op;
  store_res_t        res;
  logic [ADDR_BITS-1:0] rd_data;

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_BLOCK_RST;
      max_q <= MAX_BLOCK_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MIN_BLOCK: min_q <= cfg_i.data;
        CFG_MAX_BLOCK: max_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sequencer
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_beat = req_i.valid && in_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (req_i.valid) state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_CLASS;
      ST_CLASS: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    store_req = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_CLASS: store_req = 1'b1;
      ST_DONE:  load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_i.ready = in_ready;

  // capture request
  always_ff @(posedge clk_i) begin
    if (req_beat) begin
      is_free_q <= req_i.req_type;
      size_q    <= req_i.req_size;
      addr_q    <= req_i.freed_addr;
    end
  end

  // clamp
  always_comb begin
    byp_a   = size_q > {1'b0, max_q};
    s_clamp = (size_q[REG_W-1:0] < min_q) ? min_q : size_q[REG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLAMP) begin
      byp_a_q <= byp_a;
      sm1_q   <= (s_clamp == '0) ? '0 : s_clamp - REG_W'(1);
    end
  end

  // class lookup and stack access
  always_comb begin
    blen       = bit_len(sm1_q);
    bypass_c   = byp_a_q || (blen >= BLEN_W'(NUM_CLASSES));
    op.vld     = store_req && !bypass_c;
    op.is_free = is_free_q;
    op.cls     = blen[CLS_W-1:0];
    op.addr    = addr_q;
  end

  scflc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .res_o     (res),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLASS) begin
      cls_q    <= bypass_c ? '0 : blen[CLS_W-1:0];
      bypass_q <= bypass_c;
      hit_q    <= !bypass_c && res.hit;
      full_q   <= !bypass_c && res.full;
      pop_q    <= !bypass_c && res.pop;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_cls_q    <= cls_q;
      out_bypass_q <= bypass_q;
      out_hit_q    <= hit_q;
      out_full_q   <= full_q;
      out_addr_q   <= pop_q ? rd_data : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.size_class   = out_cls_q;
  assign rsp_o.bypass       = out_bypass_q;
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.stack_full   = out_full_q;
  assign rsp_o.granted_addr = out_addr_q;

  // checks
  a_hit_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.stack_full))
    else $error("hit and stack_full both set");

  a_bypass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.bypass) |->
      (rsp_o.size_class == '0 && !rsp_o.hit && rsp_o.granted_addr == '0))
    else $error("bypass result carries pool data");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == ST_CLAMP))
    else $error("accepted beat did not start processing");

  a_op_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.vld |-> (op.cls < CLS_W'(NUM_CLASSES)))
    else $error("store access with class out of range");

endmodule

`default_nettype wire
